/* rtl/core/flqs_pkg.sv */
// flqs_pkg: shared widths, root kind codes and transaction types of the
// focal length quadratic solver. No dependencies.
`default_nettype none

package flqs_pkg;

	// default number of fraction bits of the inputs
	localparam int FRAC_BITS_DEF = 30;

	// signed width of coefficients and partial products
	localparam int QW = 34;
	localparam int PW = 2 * QW;

	// square root chain: radicand, remainder and root widths
	localparam int XW  = 64;
	localparam int SRW = 36;
	localparam int SQW = XW / 2;

	// divider chain: magnitude width, quotient width, fraction bits
	localparam int DW  = 40;
	localparam int DQW = 64;
	localparam int DFW = 32;

	// root kind codes
	localparam logic [1:0] KIND_COMPLEX  = 2'd0;
	localparam logic [1:0] KIND_DOUBLE   = 2'd1;
	localparam logic [1:0] KIND_DISTINCT = 2'd2;

	typedef logic signed [QW-1:0] q_t;

	typedef struct packed {
		logic        [30:0] sing_first;
		logic        [30:0] sing_second;
		logic signed [31:0] u_row3_col1;
		logic signed [31:0] u_row3_col2;
		logic signed [31:0] v_row3_col1;
		logic signed [31:0] v_row3_col2;
	} in_t;

	typedef struct packed {
		logic [31:0] focal_length;
		logic [1:0]  root_kind;
		logic        valid_res;
	} out_t;

endpackage

`default_nettype wire

/* rtl/core/flqs_sqrt_cell.sv */
// flqs_sqrt_cell: one digit of a floor integer square root, registered.
// Depends on flqs_pkg for the radicand, remainder and root widths.
`default_nettype none

module flqs_sqrt_cell #(
	parameter int TW = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld,
	input  logic [flqs_pkg::SRW-1:0] rem,
	input  logic [flqs_pkg::SQW-1:0] root,
	input  logic [flqs_pkg::XW-1:0]  rad,
	input  logic [TW-1:0]            tag,
	output logic                     vld_fwd,
	output logic [flqs_pkg::SRW-1:0] rem_fwd,
	output logic [flqs_pkg::SQW-1:0] root_fwd,
	output logic [flqs_pkg::XW-1:0]  rad_fwd,
	output logic [TW-1:0]            tag_fwd
);
	import flqs_pkg::*;

	logic [SRW-1:0] part;
	logic [SRW-1:0] trial;
	logic           ge;
	logic           vld_q;
	logic [SRW-1:0] rem_q;
	logic [SQW-1:0] root_q;
	logic [XW-1:0]  rad_q;
	logic [TW-1:0]  tag_q;

	// bring down two radicand bits and try the next root bit
	always_comb begin
		part  = {rem[SRW-3:0], rad[XW-1:XW-2]};
		trial = {{(SRW-SQW-2){1'b0}}, root, 2'b01};
		ge    = part >= trial;
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld;
		end
	end

	// digit state
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? part - trial : part;
			root_q <= {root[SQW-2:0], ge};
			rad_q  <= {rad[XW-3:0], 2'b00};
			tag_q  <= tag;
		end
	end

	assign vld_fwd  = vld_q;
	assign rem_fwd  = rem_q;
	assign root_fwd = root_q;
	assign rad_fwd  = rad_q;
	assign tag_fwd  = tag_q;

endmodule

`default_nettype wire

/* rtl/core/flqs_div_cell.sv */
// flqs_div_cell: one quotient bit of a restoring unsigned divider, registered.
// Depends on flqs_pkg for the magnitude and quotient widths.
`default_nettype none

module flqs_div_cell #(
	parameter int TW = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     vld,
	input  logic [flqs_pkg::DW-1:0]  rem,
	input  logic [flqs_pkg::DW-1:0]  ud,
	input  logic [flqs_pkg::DQW-1:0] num,
	input  logic [flqs_pkg::DQW-1:0] quo,
	input  logic [TW-1:0]            tag,
	output logic                     vld_fwd,
	output logic [flqs_pkg::DW-1:0]  rem_fwd,
	output logic [flqs_pkg::DW-1:0]  ud_fwd,
	output logic [flqs_pkg::DQW-1:0] num_fwd,
	output logic [flqs_pkg::DQW-1:0] quo_fwd,
	output logic [TW-1:0]            tag_fwd
);
	import flqs_pkg::*;

	logic [DW:0]    part;
	logic [DW:0]    diff;
	logic           ge;
	logic           vld_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  ud_q;
	logic [DQW-1:0] num_q;
	logic [DQW-1:0] quo_q;
	logic [TW-1:0]  tag_q;

	// shift in one numerator bit and subtract the divisor if it fits
	always_comb begin
		part = {rem, num[DQW-1]};
		diff = part - {1'b0, ud};
		ge   = part >= {1'b0, ud};
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld;
		end
	end

	// partial remainder and quotient
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q <= ge ? diff[DW-1:0] : part[DW-1:0];
			ud_q  <= ud;
			num_q <= {num[DQW-2:0], 1'b0};
			quo_q <= {quo[DQW-2:0], ge};
			tag_q <= tag;
		end
	end

	assign vld_fwd = vld_q;
	assign rem_fwd = rem_q;
	assign ud_fwd  = ud_q;
	assign num_fwd = num_q;
	assign quo_fwd = quo_q;
	assign tag_fwd = tag_q;

endmodule

`default_nettype wire

/* rtl/core/focal_length_quadratic_solver_top.sv */
// focal_length_quadratic_solver_top: coefficient pipeline, square root and
// divider cell chains. Depends on flqs_pkg, flqs_sqrt_cell, flqs_div_cell.
`default_nettype none

// Focal length from two singular values and the third-row entries of the
// singular vector matrices. The block takes one transaction per cycle and
// returns one result per transaction, in order; it stalls as a whole only
// while the result register is full and not taken. The path runs through 8
// coefficient stages, 32 square root cells for the discriminant, 2 setup
// stages, 64 divider cells, 1 select stage, 32 square root cells for the
// focal length and the result register. Inputs are clamped to their ranges;
// focal_length is unsigned Q16.16, saturated, and 0 whenever valid_res is 0.

module focal_length_quadratic_solver_top #(
	parameter int FRAC_BITS = flqs_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_ready,
	input  flqs_pkg::in_t  item,
	output logic           result_valid,
	input  logic           result_ready,
	output flqs_pkg::out_t result
);
	import flqs_pkg::*;

	localparam q_t ONE_Q = q_t'(64'd1 << FRAC_BITS);
	localparam int NSQ   = XW / 2;
	localparam int T1W   = 3 * QW + 3;

	typedef struct packed {
		logic          neg;
		logic          zero;
		logic          sat;
		logic [DW-1:0] un;
		logic [DW-1:0] ud;
	} div_setup_t;

	// fixed-point product rounded half away from zero
	function automatic q_t mulq(input q_t x, input q_t y);
		logic signed [PW-1:0] p;
		logic        [PW-1:0] m;
		logic        [PW-1:0] half;
		p    = PW'(x) * PW'(y);
		m    = p[PW-1] ? $unsigned(-p) : $unsigned(p);
		half = PW'(1) << (FRAC_BITS - 1);
		m    = (m + half) >> FRAC_BITS;
		return p[PW-1] ? -q_t'(m[QW-1:0]) : q_t'(m[QW-1:0]);
	endfunction

	function automatic q_t clamp_u(input logic [30:0] v);
		q_t x;
		x = $signed({{(QW-31){1'b0}}, v});
		return (x > ONE_Q) ? ONE_Q : x;
	endfunction

	function automatic q_t clamp_s(input logic signed [31:0] v);
		q_t x;
		x = {{(QW-32){v[31]}}, v};
		return (x > ONE_Q) ? ONE_Q : ((x < -ONE_Q) ? -ONE_Q : x);
	endfunction

	function automatic logic [DW-1:0] absd(input logic signed [DW-1:0] v);
		return v[DW-1] ? $unsigned(-v) : $unsigned(v);
	endfunction

	// magnitudes, sign and special cases of one division
	function automatic div_setup_t div_setup(input logic signed [DW-1:0] n,
			input logic signed [DW-1:0] d);
		div_setup_t r;
		r.neg  = (n != '0) && (n[DW-1] != d[DW-1]);
		r.un   = absd(n);
		r.ud   = absd(d);
		r.zero = r.ud == '0;
		r.sat  = !r.zero && ({{DFW{1'b0}}, r.un[DW-1:DFW]} >= r.ud);
		return r;
	endfunction

	logic en;

	// stage valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic vld_s9, vld_s10, vld_s11;

	// coefficient pipeline payload
	q_t a_s1, b_s1, u1_s1, u2_s1, v1_s1, v2_s1;
	q_t a2_s2, b2_s2, uu1_s2, uu2_s2, vv1_s2, vv2_s2;
	q_t ta_s3, tb_s3, w1_s3, w2_s3, ka_s3, kb_s3, a2_s3, b2_s3;
	q_t uu1_s3, uu2_s3, vv1_s3, vv2_s3;
	q_t pa_s4, pb_s4, sa_s4, sb_s4, qa_s4, qb_s4, a2_s4, b2_s4;
	q_t ca_s5, cc_s5, ma_s5, mb_s5;
	q_t ca_s6, cb_s6, cc_s6;
	q_t ca_s7, cb_s7, cc_s7;
	logic signed [PW-1:0] bb_s7, ac_s7;
	logic [XW-1:0]  rad_s8;
	logic [T1W-1:0] tag_s8;
	logic signed [PW-1:0] disc;
	logic [1:0] kind_d;

	// discriminant square root chain
	logic           sq_vld  [0:NSQ];
	logic [SRW-1:0] sq_rem  [0:NSQ];
	logic [SQW-1:0] sq_root [0:NSQ];
	logic [XW-1:0]  sq_rad  [0:NSQ];
	logic [T1W-1:0] sq_tag  [0:NSQ];

	q_t                   ca_c, cb_c, cc_c;
	logic [1:0]           kind_c;
	logic                 nz_c;
	logic signed [DW-1:0] cbx, sx;

	logic signed [DW-1:0] p_s9, ca_s9, cb_s9, cc_s9;
	logic [1:0]           kind_s9;
	logic                 nz_s9;

	div_setup_t ds0, ds1;
	logic [DW-1:0]  d0_rem_s10, d1_rem_s10, d0_ud_s10, d1_ud_s10;
	logic [DQW-1:0] d0_num_s10, d1_num_s10;
	logic [5:0]     d0_tag_s10;
	logic [2:0]     d1_tag_s10;

	// divider chains
	logic           d0_vld [0:DQW];
	logic [DW-1:0]  d0_rem [0:DQW];
	logic [DW-1:0]  d0_ud  [0:DQW];
	logic [DQW-1:0] d0_num [0:DQW];
	logic [DQW-1:0] d0_quo [0:DQW];
	logic [5:0]     d0_tag [0:DQW];
	logic           d1_vld [0:DQW];
	logic [DW-1:0]  d1_rem [0:DQW];
	logic [DW-1:0]  d1_ud  [0:DQW];
	logic [DQW-1:0] d1_num [0:DQW];
	logic [DQW-1:0] d1_quo [0:DQW];
	logic [2:0]     d1_tag [0:DQW];

	logic [DQW-1:0] m0, m1, mag;
	logic           rneg, fin_valid;
	logic [DQW-1:0] mag_s11;
	logic [2:0]     tag_s11;

	// focal length square root chain
	logic           fl_vld  [0:NSQ];
	logic [SRW-1:0] fl_rem  [0:NSQ];
	logic [SQW-1:0] fl_root [0:NSQ];
	logic [XW-1:0]  fl_rad  [0:NSQ];
	logic [2:0]     fl_tag  [0:NSQ];

	logic res_vld_q;
	out_t res_q;

	// whole pipeline advances while the result register can take a transaction
	assign en         = !res_vld_q || result_ready;
	assign item_ready = en;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1  <= item_valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= sq_vld[NSQ];
			vld_s10 <= vld_s9;
			vld_s11 <= d0_vld[DQW];
		end
	end

	// discriminant and root kind
	always_comb begin
		disc   = bb_s7 - (ac_s7 <<< 2);
		kind_d = (disc > 0) ? KIND_DISTINCT : ((disc == 0) ? KIND_DOUBLE : KIND_COMPLEX);
	end

	// coefficient stages
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= clamp_u(item.sing_first);
			b_s1   <= clamp_u(item.sing_second);
			u1_s1  <= clamp_s(item.u_row3_col1);
			u2_s1  <= clamp_s(item.u_row3_col2);
			v1_s1  <= clamp_s(item.v_row3_col1);
			v2_s1  <= clamp_s(item.v_row3_col2);

			a2_s2  <= mulq(a_s1, a_s1);
			b2_s2  <= mulq(b_s1, b_s1);
			uu1_s2 <= mulq(u1_s1, u1_s1);
			uu2_s2 <= mulq(u2_s1, u2_s1);
			vv1_s2 <= mulq(v1_s1, v1_s1);
			vv2_s2 <= mulq(v2_s1, v2_s1);

			ta_s3  <= mulq(a2_s2, ONE_Q - uu1_s2);
			tb_s3  <= mulq(b2_s2, ONE_Q - uu2_s2);
			w1_s3  <= mulq(uu1_s2, vv1_s2);
			w2_s3  <= mulq(uu2_s2, vv2_s2);
			ka_s3  <= mulq(a2_s2, uu1_s2);
			kb_s3  <= mulq(b2_s2, uu2_s2);
			a2_s3  <= a2_s2;
			b2_s3  <= b2_s2;
			uu1_s3 <= uu1_s2;
			uu2_s3 <= uu2_s2;
			vv1_s3 <= vv1_s2;
			vv2_s3 <= vv2_s2;

			pa_s4  <= mulq(ta_s3, ONE_Q - vv1_s3);
			pb_s4  <= mulq(tb_s3, ONE_Q - vv2_s3);
			sa_s4  <= uu1_s3 + vv1_s3 - (w1_s3 <<< 1);
			sb_s4  <= uu2_s3 + vv2_s3 - (w2_s3 <<< 1);
			qa_s4  <= mulq(ka_s3, vv1_s3);
			qb_s4  <= mulq(kb_s3, vv2_s3);
			a2_s4  <= a2_s3;
			b2_s4  <= b2_s3;

			ca_s5  <= pa_s4 - pb_s4;
			cc_s5  <= qa_s4 - qb_s4;
			ma_s5  <= mulq(a2_s4, sa_s4);
			mb_s5  <= mulq(b2_s4, sb_s4);

			ca_s6  <= ca_s5;
			cb_s6  <= ma_s5 - mb_s5;
			cc_s6  <= cc_s5;

			bb_s7  <= PW'(cb_s6) * PW'(cb_s6);
			ac_s7  <= PW'(ca_s6) * PW'(cc_s6);
			ca_s7  <= ca_s6;
			cb_s7  <= cb_s6;
			cc_s7  <= cc_s6;

			rad_s8 <= (kind_d == KIND_DISTINCT) ? disc[XW-1:0] : '0;
			tag_s8 <= {ca_s7, cb_s7, cc_s7, kind_d, ca_s7 != '0};
		end
	end

	// discriminant square root chain
	assign sq_vld[0]  = vld_s8;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0]  = rad_s8;
	assign sq_tag[0]  = tag_s8;

	for (genvar k = 0; k < NSQ; k++) begin : g_sq
		flqs_sqrt_cell #(.TW(T1W)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld      (sq_vld[k]),
			.rem      (sq_rem[k]),
			.root     (sq_root[k]),
			.rad      (sq_rad[k]),
			.tag      (sq_tag[k]),
			.vld_fwd  (sq_vld[k+1]),
			.rem_fwd  (sq_rem[k+1]),
			.root_fwd (sq_root[k+1]),
			.rad_fwd  (sq_rad[k+1]),
			.tag_fwd  (sq_tag[k+1])
		);
	end

	// twice q from the discriminant root
	always_comb begin
		{ca_c, cb_c, cc_c, kind_c, nz_c} = sq_tag[NSQ];
		cbx = {{(DW-QW){cb_c[QW-1]}}, cb_c};
		sx  = $signed({{(DW-SQW){1'b0}}, sq_root[NSQ]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s9    <= (cbx >= 0) ? -(cbx + sx) : (sx - cbx);
			ca_s9   <= {{(DW-QW){ca_c[QW-1]}}, ca_c};
			cb_s9   <= cbx;
			cc_s9   <= {{(DW-QW){cc_c[QW-1]}}, cc_c};
			kind_s9 <= kind_c;
			nz_s9   <= nz_c;
		end
	end

	// division setup: 2q (or -B unless the roots are distinct) over 2A, and 2C over 2q
	always_comb begin
		ds0 = div_setup((kind_s9 == KIND_DISTINCT) ? p_s9 : -cb_s9, ca_s9 <<< 1);
		ds1 = div_setup(cc_s9 <<< 1, p_s9);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d0_rem_s10 <= {{DFW{1'b0}}, ds0.un[DW-1:DFW]};
			d0_ud_s10  <= ds0.ud;
			d0_num_s10 <= {ds0.un[DFW-1:0], {(DQW-DFW){1'b0}}};
			d0_tag_s10 <= {ds0.neg, ds0.zero, ds0.sat, kind_s9, nz_s9};
			d1_rem_s10 <= {{DFW{1'b0}}, ds1.un[DW-1:DFW]};
			d1_ud_s10  <= ds1.ud;
			d1_num_s10 <= {ds1.un[DFW-1:0], {(DQW-DFW){1'b0}}};
			d1_tag_s10 <= {ds1.neg, ds1.zero, ds1.sat};
		end
	end

	// divider chains
	assign d0_vld[0] = vld_s10;
	assign d0_rem[0] = d0_rem_s10;
	assign d0_ud[0]  = d0_ud_s10;
	assign d0_num[0] = d0_num_s10;
	assign d0_quo[0] = '0;
	assign d0_tag[0] = d0_tag_s10;
	assign d1_vld[0] = vld_s10;
	assign d1_rem[0] = d1_rem_s10;
	assign d1_ud[0]  = d1_ud_s10;
	assign d1_num[0] = d1_num_s10;
	assign d1_quo[0] = '0;
	assign d1_tag[0] = d1_tag_s10;

	for (genvar k = 0; k < DQW; k++) begin : g_div
		flqs_div_cell #(.TW(6)) u_div0 (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld     (d0_vld[k]),
			.rem     (d0_rem[k]),
			.ud      (d0_ud[k]),
			.num     (d0_num[k]),
			.quo     (d0_quo[k]),
			.tag     (d0_tag[k]),
			.vld_fwd (d0_vld[k+1]),
			.rem_fwd (d0_rem[k+1]),
			.ud_fwd  (d0_ud[k+1]),
			.num_fwd (d0_num[k+1]),
			.quo_fwd (d0_quo[k+1]),
			.tag_fwd (d0_tag[k+1])
		);
		flqs_div_cell #(.TW(3)) u_div1 (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.vld     (d1_vld[k]),
			.rem     (d1_rem[k]),
			.ud      (d1_ud[k]),
			.num     (d1_num[k]),
			.quo     (d1_quo[k]),
			.tag     (d1_tag[k]),
			.vld_fwd (d1_vld[k+1]),
			.rem_fwd (d1_rem[k+1]),
			.ud_fwd  (d1_ud[k+1]),
			.num_fwd (d1_num[k+1]),
			.quo_fwd (d1_quo[k+1]),
			.tag_fwd (d1_tag[k+1])
		);
	end

	// pick the larger nonnegative root
	always_comb begin
		m0   = d0_tag[DQW][4] ? '0 : (d0_tag[DQW][3] ? '1 : d0_quo[DQW]);
		m1   = d1_tag[DQW][1] ? '0 : (d1_tag[DQW][0] ? '1 : d1_quo[DQW]);
		mag  = m0;
		rneg = 1'b0;
		if (d0_tag[DQW][2:1] == KIND_DISTINCT) begin
			if (!d0_tag[DQW][5] && !d1_tag[DQW][2]) begin
				mag = (m0 > m1) ? m0 : m1;
			end else if (!d0_tag[DQW][5]) begin
				mag = m0;
			end else if (!d1_tag[DQW][2]) begin
				mag = m1;
			end else begin
				rneg = 1'b1;
			end
		end else begin
			rneg = d0_tag[DQW][5];
		end
		fin_valid = d0_tag[DQW][0] && !rneg;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s11 <= mag;
			tag_s11 <= {d0_tag[DQW][2:1], fin_valid};
		end
	end

	// focal length square root chain
	assign fl_vld[0]  = vld_s11;
	assign fl_rem[0]  = '0;
	assign fl_root[0] = '0;
	assign fl_rad[0]  = mag_s11;
	assign fl_tag[0]  = tag_s11;

	for (genvar k = 0; k < NSQ; k++) begin : g_fl
		flqs_sqrt_cell #(.TW(3)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.vld      (fl_vld[k]),
			.rem      (fl_rem[k]),
			.root     (fl_root[k]),
			.rad      (fl_rad[k]),
			.tag      (fl_tag[k]),
			.vld_fwd  (fl_vld[k+1]),
			.rem_fwd  (fl_rem[k+1]),
			.root_fwd (fl_root[k+1]),
			.rad_fwd  (fl_rad[k+1]),
			.tag_fwd  (fl_tag[k+1])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= fl_vld[NSQ];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.focal_length <= fl_tag[NSQ][0] ? fl_root[NSQ] : '0;
			res_q.root_kind    <= fl_tag[NSQ][2:1];
			res_q.valid_res    <= fl_tag[NSQ][0];
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	// a positive discriminant has a nonzero root
	a_disc_root: assert property (@(posedge clk) disable iff (!arst_n)
		sq_vld[NSQ] && (sq_tag[NSQ][2:1] == KIND_DISTINCT) |-> sq_root[NSQ] != '0)
		else $error("zero root of positive discriminant");

	// both divider chains carry the same transaction
	a_div_align: assert property (@(posedge clk) disable iff (!arst_n)
		d0_vld[DQW] == d1_vld[DQW])
		else $error("divider chains out of step");

	// rejected results report no focal length
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.valid_res |-> result.focal_length == '0)
		else $error("focal length on invalid result");

	// root kind is a defined code
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.root_kind == KIND_COMPLEX ||
			result.root_kind == KIND_DOUBLE || result.root_kind == KIND_DISTINCT))
		else $error("undefined root kind");

endmodule

`default_nettype wire

/* tb/tb_focal_length_quadratic_solver_top.sv */
// tb_focal_length_quadratic_solver_top: self-checking bench for the focal length solver.
// Depends on flqs_pkg and focal_length_quadratic_solver_top; predicts each result in place.
`timescale 1ns / 1ps

module tb_focal_length_quadratic_solver_top;
	import flqs_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam longint ONE = longint'(1) << FB;
	localparam int LATENCY = 140;
	localparam longint CYCLE_LIMIT = 1000000;

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	in_t item;
	logic result_valid;
	logic result_ready;
	out_t result;

	out_t focal_queue[$];
	int n_sent, n_checked, n_errors, n_valid, n_kind[3];
	longint cycles;
	bit stall_enable;

	focal_length_quadratic_solver_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// cycle limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout at %0t", $time);
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// fixed-point product, rounded half away from zero
	function automatic longint fx_mul(longint x, longint y);
		longint p;
		longint m;
		p = x * y;
		m = p < 0 ? -p : p;
		m = (m + (longint'(1) << (FB - 1))) >>> FB;
		return p < 0 ? -m : m;
	endfunction

	function automatic logic [63:0] int_sqrt(logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// |n|/|d| as unsigned Q32.32, truncated and saturated
	function automatic logic [63:0] ratio_q32(longint n, longint d, output bit neg);
		logic [63:0] un, ud, ip, r, frac;
		neg = (n != 0) && ((n < 0) != (d < 0));
		if (d == 0) return 0;
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		ip = un / ud;
		if (ip >= 64'h1_0000_0000) return '1;
		r = un % ud;
		frac = 0;
		for (int i = 0; i < 32; i++) begin
			r <<= 1;
			frac <<= 1;
			if (r >= ud) begin
				r -= ud;
				frac[0] = 1'b1;
			end
		end
		return (ip << 32) | frac;
	endfunction

	function automatic longint clip(longint x, longint lo, longint hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic out_t solve_focal(in_t t);
		longint a, b, u1, u2, v1, v2, a2, b2, uu1, uu2, vv1, vv2;
		longint ca, cb, cc, s, p;
		logic signed [127:0] disc;
		logic [63:0] mag, m0, m1;
		bit rneg, n0, n1, ok;
		out_t o;
		a = clip(longint'(t.sing_first), 0, ONE);
		b = clip(longint'(t.sing_second), 0, ONE);
		u1 = clip(longint'(t.u_row3_col1), -ONE, ONE);
		u2 = clip(longint'(t.u_row3_col2), -ONE, ONE);
		v1 = clip(longint'(t.v_row3_col1), -ONE, ONE);
		v2 = clip(longint'(t.v_row3_col2), -ONE, ONE);
		a2 = fx_mul(a, a);
		b2 = fx_mul(b, b);
		uu1 = fx_mul(u1, u1);
		uu2 = fx_mul(u2, u2);
		vv1 = fx_mul(v1, v1);
		vv2 = fx_mul(v2, v2);
		ca = fx_mul(fx_mul(a2, ONE - uu1), ONE - vv1) - fx_mul(fx_mul(b2, ONE - uu2), ONE - vv2);
		cb = fx_mul(a2, uu1 + vv1 - 2 * fx_mul(uu1, vv1))
			- fx_mul(b2, uu2 + vv2 - 2 * fx_mul(uu2, vv2));
		cc = fx_mul(fx_mul(a2, uu1), vv1) - fx_mul(fx_mul(b2, uu2), vv2);
		disc = 128'(cb) * 128'(cb) - 128'sd4 * (128'(ca) * 128'(cc));
		o.root_kind = disc > 0 ? KIND_DISTINCT : (disc == 0 ? KIND_DOUBLE : KIND_COMPLEX);
		ok = ca != 0;
		mag = 0;
		rneg = 0;
		if (ok) begin
			if (o.root_kind == KIND_DISTINCT) begin
				s = longint'(int_sqrt(disc[63:0]));
				p = cb >= 0 ? -(cb + s) : (s - cb);
				m0 = ratio_q32(p, 2 * ca, n0);
				m1 = ratio_q32(2 * cc, p, n1);
				if (!n0 && !n1) mag = m0 > m1 ? m0 : m1;
				else if (!n0) mag = m0;
				else if (!n1) mag = m1;
				else rneg = 1;
			end else begin
				mag = ratio_q32(-cb, 2 * ca, rneg);
			end
			if (rneg) ok = 0;
		end
		o.focal_length = ok ? 32'(int_sqrt(mag)) : 32'd0;
		o.valid_res = ok;
		return o;
	endfunction

	// one transaction on the input channel
	task automatic send_item(in_t t);
		item <= t;
		item_valid <= 1'b1;
		focal_queue.push_back(solve_focal(t));
		do @(posedge clk); while (!item_ready);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic idle_input();
		item_valid <= 1'b0;
	endtask

	// result checker
	always @(posedge clk) begin
		out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (focal_queue.size() == 0) begin
				$display("%0t unexpected result %h", $time, result);
				n_errors++;
			end else begin
				want = focal_queue.pop_front();
				n_checked++;
				if (result.valid_res) n_valid++;
				if (result.root_kind < 3) n_kind[result.root_kind]++;
				if (result.focal_length !== want.focal_length) begin
					$display("%0t focal_length expected %h actual %h", $time,
						want.focal_length, result.focal_length);
					n_errors++;
				end
				if (result.root_kind !== want.root_kind) begin
					$display("%0t root_kind expected %0d actual %0d", $time,
						want.root_kind, result.root_kind);
					n_errors++;
				end
				if (result.valid_res !== want.valid_res) begin
					$display("%0t valid_res expected %0d actual %0d", $time,
						want.valid_res, result.valid_res);
					n_errors++;
				end
			end
		end
	end

	// receiver stall pattern: runs of ready and of stall
	initial begin
		int run;
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (run == 0) begin
				run = $urandom_range(1, 30);
				if (stall_enable) result_ready <= ($urandom_range(0, 2) != 0);
				else result_ready <= 1'b1;
			end
			run--;
		end
	end

	// random bursts on the sender side
	task automatic maybe_gap(ref int burst);
		if (burst > 0) begin
			burst--;
			return;
		end
		burst = $urandom_range(0, 40);
		idle_input();
		repeat ($urandom_range(1, 8)) @(negedge clk);
	endtask

	function automatic logic signed [31:0] rand_entry();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 32'(ONE);
			1: return -32'(ONE);
			2: return 32'(0);
			3: return $urandom();
			default: return 32'($urandom_range(0, 2 * ONE)) - 32'(ONE);
		endcase
	endfunction

	function automatic logic [30:0] rand_sing();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return 31'(ONE);
			1: return 31'd0;
			2: return 31'($urandom());
			default: return 31'($urandom_range(0, ONE));
		endcase
	endfunction

	function automatic in_t make_item(logic [30:0] a, logic [30:0] b, logic signed [31:0] u1,
		logic signed [31:0] u2, logic signed [31:0] v1, logic signed [31:0] v2);
		in_t t;
		t.sing_first = a;
		t.sing_second = b;
		t.u_row3_col1 = u1;
		t.u_row3_col2 = u2;
		t.v_row3_col1 = v1;
		t.v_row3_col2 = v2;
		return t;
	endfunction

	// extremes, clamping, zero leading coefficient, double and complex roots
	task automatic test_directed();
		localparam logic signed [31:0] P = 32'(ONE);
		localparam logic signed [31:0] H = 32'(ONE / 2);
		send_item(make_item(0, 0, 0, 0, 0, 0));
		send_item(make_item(31'(ONE), 31'(ONE), P, P, P, P));
		send_item(make_item('1, '1, '1, 32'h7fffffff, 32'h80000000, -P));
		send_item(make_item(31'(ONE), 0, 0, 0, 0, 0));
		send_item(make_item(0, 31'(ONE), 0, 0, 0, 0));
		send_item(make_item(31'(ONE), 31'(ONE / 2), H, 0, H, 0));
		send_item(make_item(31'(ONE), 31'(ONE / 2), 0, H, 0, H));
		send_item(make_item(31'(ONE), 31'(ONE), H, H, H, H));
		send_item(make_item(31'(ONE), 31'(ONE / 3), H, -H, -H, H));
		send_item(make_item(31'(ONE), 31'(ONE), P, 0, 0, 0));
		send_item(make_item(31'(ONE), 31'(ONE / 4), -H, H, H, -H));
		send_item(make_item(31'(ONE), 31'(ONE - 1), 1, -1, 1, -1));
		send_item(make_item(31'(ONE), 31'(ONE), P, P, 0, 0));
		send_item(make_item(31'(ONE / 2), 31'(ONE), H, 0, 0, H));
		send_item(make_item(31'h2aaaaaaa, 31'h15555555, 32'h55555555, 32'haaaaaaaa,
			32'h2aaaaaaa, 32'hd5555555));
		idle_input();
	endtask

	// random items with bursts and gaps
	task automatic test_random(int count);
		int burst;
		burst = 0;
		for (int i = 0; i < count; i++) begin
			maybe_gap(burst);
			send_item(make_item(rand_sing(), rand_sing(), rand_entry(), rand_entry(),
				rand_entry(), rand_entry()));
		end
		idle_input();
	endtask

	task automatic wait_drained();
		while (focal_queue.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		stall_enable = 1'b0;
		n_sent = 0;
		n_checked = 0;
		n_errors = 0;
		n_valid = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		stall_enable = 1'b1;
		test_random(1600);
		wait_drained();
		$display("sent %0d transactions, checked %0d results (%0d valid)", n_sent, n_checked,
			n_valid);
		$display("root kinds: complex %0d, double %0d, distinct %0d", n_kind[0], n_kind[1],
			n_kind[2]);
		if (n_errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
